FILE: rtl/swmf_pkg.sv
// Shared types and constants of the sliding window median filter.
// Used by the sorting cells and the top level; no dependencies.
package swmf_pkg;

    // Width of the window length register and its value after reset.
    localparam int unsigned CFG_W = 6;
    localparam logic [CFG_W-1:0] WL_RESET = 6'd32;

    // Flags that one sorting cell hands to its neighbors in the same cycle.
    typedef struct packed {
        logic not_above;   // stored value <= incoming sample
        logic del_seen;    // the entry being replaced sits at this cell or to its left
    } link_t;

endpackage

FILE: rtl/swmf_cell.sv
// One cell of the sorted chain: holds one ring entry (value and ring index).
// Depends on swmf_pkg for the neighbor link struct.
module swmf_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int IDX_W        = 5,
    parameter int CELL_IDX     = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upd,
    input  logic signed [SAMPLE_WIDTH-1:0] new_val,
    input  logic        [IDX_W-1:0]        wp,
    input  logic                           del_in,
    input  logic                           left_not_above,
    input  logic                           right_not_above,
    input  logic signed [SAMPLE_WIDTH-1:0] left_val,
    input  logic        [IDX_W-1:0]        left_idx,
    input  logic signed [SAMPLE_WIDTH-1:0] right_val,
    input  logic        [IDX_W-1:0]        right_idx,
    output swmf_pkg::link_t                link,
    output logic signed [SAMPLE_WIDTH-1:0] val,
    output logic        [IDX_W-1:0]        idx
);

    logic signed [SAMPLE_WIDTH-1:0] val_reg, val_next;
    logic        [IDX_W-1:0]        idx_reg, idx_next;
    logic                           not_above;
    logic                           del_self;
    logic                           del_here;
    logic                           prev_not_above;
    logic signed [SAMPLE_WIDTH-1:0] prev_val;
    logic        [IDX_W-1:0]        prev_idx;

    assign not_above = (val_reg <= new_val);
    assign del_self  = (idx_reg == wp);
    assign del_here  = del_in | del_self;

    // After the replaced entry is taken out, the element in front of this
    // position is this cell itself when the removal happened further left.
    assign prev_not_above = del_in ? not_above : left_not_above;
    assign prev_val       = del_in ? val_reg   : left_val;
    assign prev_idx       = del_in ? idx_reg   : left_idx;

    always_comb
    begin
        val_next = val_reg;
        idx_next = idx_reg;
        if (!del_here)
        begin
            if (!not_above)
            begin
                if (left_not_above)
                begin
                    val_next = new_val;
                    idx_next = wp;
                end
                else
                begin
                    val_next = left_val;
                    idx_next = left_idx;
                end
            end
        end
        else if (right_not_above)
        begin
            val_next = right_val;
            idx_next = right_idx;
        end
        else if (prev_not_above)
        begin
            val_next = new_val;
            idx_next = wp;
        end
        else
        begin
            val_next = prev_val;
            idx_next = prev_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            idx_reg <= IDX_W'(CELL_IDX);
        end
        else if (upd)
        begin
            val_reg <= val_next;
            idx_reg <= idx_next;
        end
    end

    assign link.not_above = not_above;
    assign link.del_seen  = del_here;
    assign val            = val_reg;
    assign idx            = idx_reg;

endmodule

FILE: rtl/swmf_select.sv
// Rank scanner: walks the sorted chain and picks the middle in-window entry,
// then holds it in the output register. Uses no package items.
module swmf_select #(
    parameter int N            = 32,
    parameter int SAMPLE_WIDTH = 16,
    parameter int IDX_W        = 5,
    parameter int LEN_W        = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic        [LEN_W-1:0]        len,
    input  logic signed [SAMPLE_WIDTH-1:0] cell_val [N],
    input  logic        [IDX_W-1:0]        cell_idx [N],
    input  logic                           median_ready,
    output logic                           busy,
    output logic signed [SAMPLE_WIDTH-1:0] median,
    output logic                           median_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [IDX_W-1:0]               sc_reg, sc_next;
    logic [LEN_W-1:0]               cnt_reg, cnt_next;
    logic signed [SAMPLE_WIDTH-1:0] pick_reg, pick_next;
    logic signed [SAMPLE_WIDTH-1:0] median_reg, median_next;
    logic                           ov_reg, ov_next;
    logic [LEN_W-1:0]               target;
    logic                           in_win;
    logic                           hit;
    logic                           out_free;

    assign target   = len >> 1;
    assign in_win   = (LEN_W'(cell_idx[sc_reg]) < len);
    assign hit      = in_win && (cnt_reg == target);
    assign out_free = !ov_reg || median_ready;

    always_comb
    begin
        state_next  = state_reg;
        sc_next     = sc_reg;
        cnt_next    = cnt_reg;
        pick_next   = pick_reg;
        median_next = median_reg;
        ov_next     = ov_reg && !median_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sc_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    pick_next  = cell_val[sc_reg];
                    state_next = ST_WAIT;
                end
                else
                begin
                    if (in_win)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    sc_next = sc_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    median_next = pick_reg;
                    ov_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sc_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg   <= pick_next;
        median_reg <= median_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign median       = median_reg;
    assign median_valid = ov_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("new transaction started while a scan is in progress");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg <= target)
        else $error("in-window count passed the median rank");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !hit) |-> sc_reg != IDX_W'(N - 1))
        else $error("scan reached the end of the chain without a pick");

    a_wait_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && out_free) |=> (state_reg == ST_IDLE && ov_reg))
        else $error("picked median was not moved to the output register");

endmodule

FILE: rtl/sliding_window_median_filter.sv
// Top level of the sliding window median filter: sorted cell chain, ring
// write pointer, window length register and rank scanner. Uses swmf_pkg,
// swmf_cell and swmf_select.
//
//   Channel   Direction  Signals                                  Handshake
//   -------   ---------  ---------------------------------------  ----------------
//   input     in         sample_valid, sample_ready, sample        valid / ready
//   output    out        median_valid, median_ready, median        valid / ready
//   config    in         window_length_wr_en, window_length        write enable only
//
// An input transaction updates the cell chain in the cycle it is accepted;
// the scanner then walks the chain one cell per cycle up to the middle
// in-window entry and stays busy until that pick is in the output register.
// sample_ready is high whenever the scanner is idle, even if a finished median
// still waits in the output register; a stalled output holds the next pick in
// the scanner, which keeps sample_ready low. Reset puts zeros in every ring
// entry, the write pointer at entry 0 and the window length at 32; no clearing
// pass is needed.
module sliding_window_median_filter #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           median_valid,
    input  logic                           median_ready,
    output logic signed [SAMPLE_WIDTH-1:0] median,
    input  logic                           window_length_wr_en,
    input  logic [swmf_pkg::CFG_W-1:0]     window_length
);

    // Ring index width, and a length width that holds both MAX_WINDOW and
    // any value of the length register.
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (LW > swmf_pkg::CFG_W) ? LW : swmf_pkg::CFG_W;

    logic [swmf_pkg::CFG_W-1:0]     wl_reg;
    logic [IDX_W-1:0]               wp_reg, wp_next;
    logic [IDX_W-1:0]               wp_use;
    logic [LEN_W-1:0]               wl_ext;
    logic [LEN_W-1:0]               len;
    logic [LEN_W-1:0]               wp_inc;
    logic                           accept;
    logic                           busy;

    swmf_pkg::link_t                link     [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_val [MAX_WINDOW];
    logic        [IDX_W-1:0]        cell_idx [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]   at_wp;

    assign accept       = sample_valid && sample_ready;
    assign sample_ready = !busy;

    // A length of zero acts as one and anything above the ring size is
    // clamped to the ring size.
    assign wl_ext = LEN_W'(wl_reg);
    always_comb
    begin
        if (wl_ext == '0)
        begin
            len = LEN_W'(1);
        end
        else if (wl_ext > LEN_W'(MAX_WINDOW))
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = wl_ext;
        end
    end

    // If the window shrank below the pointer, the next sample goes to entry 0.
    assign wp_use = (LEN_W'(wp_reg) >= len) ? '0 : wp_reg;
    assign wp_inc = LEN_W'(wp_use) + 1'b1;
    assign wp_next = (wp_inc >= len) ? '0 : IDX_W'(wp_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= swmf_pkg::WL_RESET;
            wp_reg <= '0;
        end
        else
        begin
            if (window_length_wr_en)
            begin
                wl_reg <= window_length;
            end
            if (accept)
            begin
                wp_reg <= wp_next;
            end
        end
    end

    // The chain keeps all ring entries sorted by value. On a transaction the
    // entry with index wp_use leaves and the new sample takes its place in
    // sorted order, each cell looking only at its two neighbors.
    for (genvar g = 0; g < MAX_WINDOW; g++)
    begin : g_cell
        logic                           left_na;
        logic                           right_na;
        logic                           del_in;
        logic signed [SAMPLE_WIDTH-1:0] left_val;
        logic signed [SAMPLE_WIDTH-1:0] right_val;
        logic        [IDX_W-1:0]        left_idx;
        logic        [IDX_W-1:0]        right_idx;

        if (g == 0)
        begin : g_first
            assign left_na  = 1'b1;
            assign del_in   = 1'b0;
            assign left_val = '0;
            assign left_idx = '0;
        end
        else
        begin : g_inner_l
            assign left_na  = link[g-1].not_above;
            assign del_in   = link[g-1].del_seen;
            assign left_val = cell_val[g-1];
            assign left_idx = cell_idx[g-1];
        end

        if (g == MAX_WINDOW - 1)
        begin : g_last
            assign right_na  = 1'b0;
            assign right_val = '0;
            assign right_idx = '0;
        end
        else
        begin : g_inner_r
            assign right_na  = link[g+1].not_above;
            assign right_val = cell_val[g+1];
            assign right_idx = cell_idx[g+1];
        end

        swmf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .IDX_W        (IDX_W),
            .CELL_IDX     (g)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .upd             (accept),
            .new_val         (sample),
            .wp              (wp_use),
            .del_in          (del_in),
            .left_not_above  (left_na),
            .right_not_above (right_na),
            .left_val        (left_val),
            .left_idx        (left_idx),
            .right_val       (right_val),
            .right_idx       (right_idx),
            .link            (link[g]),
            .val             (cell_val[g]),
            .idx             (cell_idx[g])
        );

        assign at_wp[g] = (cell_idx[g] == wp_use);
    end

    swmf_select #(
        .N            (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDX_W        (IDX_W),
        .LEN_W        (LEN_W)
    ) u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .len          (len),
        .cell_val     (cell_val),
        .cell_idx     (cell_idx),
        .median_ready (median_ready),
        .busy         (busy),
        .median       (median),
        .median_valid (median_valid)
    );

    // Every ring index lives in exactly one cell, so exactly one cell is
    // replaced on each transaction.
    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(at_wp))
        else $error("write position does not match exactly one cell");

endmodule
